@@ src/mlfq_pkg.sv @@
// Shared types and constants for the multilevel feedback queue scheduler.
`timescale 1ns / 1ps
package mlfq_pkg;
	localparam int LEVELS = 8;
	localparam int LEVEL_DEPTH = 64;
	localparam int LVW = $clog2(LEVELS);
	localparam int SLOTW = $clog2(LEVEL_DEPTH);
	localparam int FILLW = SLOTW + 1;
	localparam int ADDRW = LVW + SLOTW;
	localparam int ENTW = 62;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_RAN = 3'd1;
	localparam logic [2:0] ST_DONE = 3'd2;
	localparam logic [2:0] ST_ADMIT = 3'd3;
	localparam logic [2:0] ST_REJECT = 3'd4;

	localparam logic [1:0] REG_LEVEL_COUNT = 2'd0;
	localparam logic [1:0] REG_SLICE = 2'd1;
	localparam logic [1:0] REG_BOOST = 2'd2;

	typedef struct packed {
		logic [5:0] id;
		logic [15:0] remaining;
		logic [7:0] used;
		logic [31:0] arrival;
	} job_t;

	// datapath commands
	typedef enum logic [3:0] {
		OP_NONE,
		OP_ADMIT,
		OP_TICK_FIND,
		OP_TICK_READ,
		OP_TICK_EXEC,
		OP_BOOST_START,
		OP_BOOST_READ,
		OP_BOOST_MOVE
	} op_t;

	typedef struct packed {
		logic found;
		logic boundary;
		logic boost_more;
		logic boost_last;
		logic any_queued;
	} dp_status_t;
endpackage

@@ src/multilevel_feedback_queue_scheduler.sv @@
// Top level of the multilevel feedback queue scheduler.
`timescale 1ns / 1ps
// Usage: s_axis carries items (admit a job or one time tick); m_axis carries
// one result beat per item. The APB port writes level_count (0x0),
// slice_table (0x8) and boost_period (0x10); the user writes them only
// while the block is idle, which the block does not enforce. Steps: an
// admit is accepted and then output; a tick goes through find level, read
// queue head, execute, boost check and output. A boost sweeps levels 1..7
// with a read and a move per job queued there, through the queue memory.
// One item is in flight at a time; s_axis_tready is low until the result
// beat has been taken, so a stalled receiver holds the block.
// Reset clears pointers, fills, time and the boost countdown; the queue
// memory itself is not cleared since only occupied slots are read.
// Registers return to their reset values: 3 levels, slices 1,2,3.., no boost.
module multilevel_feedback_queue_scheduler (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	input logic [23:0] s_axis_tdata, // job_id[5:0], job_length[21:6], pad
	input logic s_axis_tuser, // mode
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	// status[2:0], ran_id[8:3], ran_level[11:9], turnaround[43:12],
	// boosted[44], now[76:45], pad
	output logic [79:0] m_axis_tdata,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [4:0] paddr,
	input logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic pready
);
	logic [3:0] level_count_q;
	logic [63:0] slice_q;
	logic [15:0] boost_q;
	logic [1:0] ridx;
	mlfq_pkg::op_t op;
	mlfq_pkg::dp_status_t st;
	logic [2:0] r_status, r_level;
	logic [5:0] r_id;
	logic [31:0] r_turn, r_now;
	logic r_boosted;

	assign pready = 1'b1;
	assign ridx = paddr[4:3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_count_q <= 4'd3;
			slice_q <= 64'd578437695752307201;
			boost_q <= '0;
		end else if (psel && penable && pwrite && paddr[2:0] == 3'd0) begin
			case (ridx)
				mlfq_pkg::REG_LEVEL_COUNT: level_count_q <= pwdata[3:0];
				mlfq_pkg::REG_SLICE: slice_q <= pwdata;
				mlfq_pkg::REG_BOOST: boost_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (ridx)
			mlfq_pkg::REG_LEVEL_COUNT: prdata = {60'd0, level_count_q};
			mlfq_pkg::REG_SLICE: prdata = slice_q;
			mlfq_pkg::REG_BOOST: prdata = {48'd0, boost_q};
			default: prdata = '0;
		endcase
	end

	mlfq_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_mode(s_axis_tuser),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.out_boosted(r_boosted), .st(st), .op(op)
	);

	mlfq_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .op(op),
		.in_id(s_axis_tdata[5:0]), .in_len(s_axis_tdata[21:6]),
		.level_count(level_count_q), .slice_table(slice_q), .boost_period(boost_q),
		.st(st), .res_status(r_status), .res_id(r_id), .res_level(r_level),
		.res_turn(r_turn), .res_now(r_now)
	);

	assign m_axis_tdata = {3'd0, r_now, r_boosted, r_turn, r_level, r_id, r_status};
endmodule

@@ src/mlfq_datapath.sv @@
// Queue memory, level pointers, time and boost counters for the scheduler.
`timescale 1ns / 1ps
module mlfq_datapath (
	input logic clk,
	input logic arst_n,
	input mlfq_pkg::op_t op,
	input logic [5:0] in_id,
	input logic [15:0] in_len,
	input logic [3:0] level_count,
	input logic [63:0] slice_table,
	input logic [15:0] boost_period,
	output mlfq_pkg::dp_status_t st,
	output logic [2:0] res_status,
	output logic [5:0] res_id,
	output logic [2:0] res_level,
	output logic [31:0] res_turn,
	output logic [31:0] res_now
);
	mlfq_pkg::job_t mem [mlfq_pkg::LEVELS*mlfq_pkg::LEVEL_DEPTH];
	mlfq_pkg::job_t rd_q;
	logic [mlfq_pkg::ADDRW-1:0] raddr, waddr;
	logic we;
	mlfq_pkg::job_t wdata;

	logic [mlfq_pkg::SLOTW-1:0] head_q [mlfq_pkg::LEVELS];
	logic [mlfq_pkg::SLOTW-1:0] tail_q [mlfq_pkg::LEVELS];
	logic [mlfq_pkg::FILLW-1:0] fill_q [mlfq_pkg::LEVELS];
	logic [31:0] time_q;
	logic [15:0] cnt_q;
	logic started_q;
	logic boundary_q, found_q;
	logic [mlfq_pkg::LVW-1:0] lv_q;
	logic [mlfq_pkg::LVW-1:0] blv_q;
	logic [mlfq_pkg::FILLW-1:0] bn_q;

	logic [3:0] lcnt;
	logic found_c;
	logic [mlfq_pkg::LVW-1:0] lv_c;
	logic any_c;

	assign lcnt = (level_count == 4'd0) ? 4'd1 :
		(level_count > 4'(mlfq_pkg::LEVELS)) ? 4'(mlfq_pkg::LEVELS) : level_count;

	always_comb begin
		found_c = 1'b0;
		lv_c = '0;
		any_c = 1'b0;
		for (int i = mlfq_pkg::LEVELS - 1; i >= 0; i--) begin
			if (fill_q[i] != '0) begin
				any_c = 1'b1;
				if (4'(i) < lcnt) begin
					found_c = 1'b1;
					lv_c = mlfq_pkg::LVW'(i);
				end
			end
		end
	end

	assign st.found = found_q;
	assign st.boundary = boundary_q;
	assign st.any_queued = any_c;
	assign st.boost_more = (bn_q != '0);
	assign st.boost_last = (blv_q == mlfq_pkg::LVW'(mlfq_pkg::LEVELS - 1));

	always_comb begin
		case (op)
			mlfq_pkg::OP_BOOST_READ: raddr = {blv_q, head_q[blv_q]};
			default: raddr = {lv_q, head_q[lv_q]};
		endcase
	end

	always_ff @(posedge clk) begin
		rd_q <= mem[raddr];
		if (we)
			mem[waddr] <= wdata;
	end

	// exec decisions
	mlfq_pkg::job_t j;
	logic [7:0] slc, used_n;
	logic tgt_ok;
	logic [mlfq_pkg::LVW-1:0] tgt;
	always_comb begin
		j = rd_q;
		slc = slice_table[8*lv_q +: 8];
		used_n = (rd_q.used == 8'hFF) ? 8'hFF : rd_q.used + 8'd1;
		tgt_ok = (4'(lv_q) + 4'd1 < lcnt) &&
			(fill_q[lv_q + 1'b1] != mlfq_pkg::FILLW'(mlfq_pkg::LEVEL_DEPTH));
		tgt = tgt_ok ? lv_q + 1'b1 : lv_q;
		we = 1'b0;
		waddr = '0;
		wdata = rd_q;
		case (op)
			mlfq_pkg::OP_ADMIT: begin
				we = fill_q[0] != mlfq_pkg::FILLW'(mlfq_pkg::LEVEL_DEPTH);
				waddr = {mlfq_pkg::LVW'(0), tail_q[0]};
				wdata = '{id: in_id, remaining: in_len, used: 8'd0, arrival: time_q};
			end
			mlfq_pkg::OP_TICK_EXEC: begin
				j.remaining = rd_q.remaining - 16'd1;
				j.used = used_n;
				if (found_q && rd_q.remaining > 16'd1) begin
					we = 1'b1;
					if (used_n >= slc) begin
						j.used = 8'd0;
						waddr = {tgt, tail_q[tgt]};
					end else
						waddr = {lv_q, head_q[lv_q]};
					wdata = j;
				end
			end
			mlfq_pkg::OP_BOOST_MOVE: begin
				we = 1'b1;
				if (fill_q[0] != mlfq_pkg::FILLW'(mlfq_pkg::LEVEL_DEPTH)) begin
					waddr = {mlfq_pkg::LVW'(0), tail_q[0]};
					j.used = 8'd0;
				end else
					waddr = {blv_q, tail_q[blv_q]};
				wdata = j;
			end
			default: ;
		endcase
	end

	function automatic logic [mlfq_pkg::SLOTW-1:0] nxt(input logic [mlfq_pkg::SLOTW-1:0] s);
		nxt = (32'(s) + 1 >= mlfq_pkg::LEVEL_DEPTH) ? '0 : s + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < mlfq_pkg::LEVELS; i++) begin
				head_q[i] <= '0;
				tail_q[i] <= '0;
				fill_q[i] <= '0;
			end
			time_q <= '0;
			cnt_q <= '0;
			started_q <= 1'b0;
			boundary_q <= 1'b0;
			found_q <= 1'b0;
			lv_q <= '0;
			blv_q <= '0;
			bn_q <= '0;
			res_status <= '0;
			res_id <= '0;
			res_level <= '0;
			res_turn <= '0;
		end else begin
			case (op)
				mlfq_pkg::OP_ADMIT: begin
					res_id <= in_id;
					res_level <= '0;
					res_turn <= '0;
					if (fill_q[0] != mlfq_pkg::FILLW'(mlfq_pkg::LEVEL_DEPTH)) begin
						tail_q[0] <= nxt(tail_q[0]);
						fill_q[0] <= fill_q[0] + 1'b1;
						res_status <= mlfq_pkg::ST_ADMIT;
						if (!started_q) begin
							started_q <= 1'b1;
							cnt_q <= boost_period;
						end
					end else
						res_status <= mlfq_pkg::ST_REJECT;
				end
				mlfq_pkg::OP_TICK_FIND: begin
					found_q <= found_c;
					lv_q <= lv_c;
					time_q <= time_q + 32'd1;
					boundary_q <= started_q && (boost_period != 16'd0) && (cnt_q <= 16'd1);
					if (started_q && boost_period != 16'd0) begin
						if (cnt_q <= 16'd1)
							cnt_q <= boost_period;
						else
							cnt_q <= cnt_q - 16'd1;
					end
				end
				mlfq_pkg::OP_TICK_EXEC: begin
					res_id <= found_q ? rd_q.id : 6'd0;
					res_level <= found_q ? 3'(lv_q) : 3'd0;
					res_turn <= (found_q && rd_q.remaining <= 16'd1) ?
						time_q - rd_q.arrival : 32'd0;
					if (!found_q)
						res_status <= mlfq_pkg::ST_IDLE;
					else if (rd_q.remaining <= 16'd1) begin
						res_status <= mlfq_pkg::ST_DONE;
						head_q[lv_q] <= nxt(head_q[lv_q]);
						fill_q[lv_q] <= fill_q[lv_q] - 1'b1;
					end else begin
						res_status <= mlfq_pkg::ST_RAN;
						if (used_n >= slc) begin
							head_q[lv_q] <= nxt(head_q[lv_q]);
							if (tgt != lv_q) begin
								fill_q[lv_q] <= fill_q[lv_q] - 1'b1;
								fill_q[tgt] <= fill_q[tgt] + 1'b1;
							end
							tail_q[tgt] <= nxt(tail_q[tgt]);
						end
					end
				end
				mlfq_pkg::OP_BOOST_START: begin
					blv_q <= mlfq_pkg::LVW'(1);
					bn_q <= fill_q[1];
				end
				mlfq_pkg::OP_BOOST_READ: begin
					if (bn_q == '0 && blv_q != mlfq_pkg::LVW'(mlfq_pkg::LEVELS - 1)) begin
						blv_q <= blv_q + 1'b1;
						bn_q <= fill_q[blv_q + 1'b1];
					end
				end
				mlfq_pkg::OP_BOOST_MOVE: begin
					bn_q <= bn_q - 1'b1;
					head_q[blv_q] <= nxt(head_q[blv_q]);
					if (fill_q[0] != mlfq_pkg::FILLW'(mlfq_pkg::LEVEL_DEPTH)) begin
						fill_q[blv_q] <= fill_q[blv_q] - 1'b1;
						fill_q[0] <= fill_q[0] + 1'b1;
						tail_q[0] <= nxt(tail_q[0]);
					end else
						tail_q[blv_q] <= nxt(tail_q[blv_q]);
				end
				default: ;
			endcase
		end
	end

	assign res_now = time_q;
endmodule

@@ src/mlfq_ctrl.sv @@
// Sequencer for admit, tick and boost sweeps; owns the output beat.
`timescale 1ns / 1ps
module mlfq_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic in_mode,
	output logic out_valid,
	input logic out_ready,
	output logic out_boosted,
	input mlfq_pkg::dp_status_t st,
	output mlfq_pkg::op_t op
);
	typedef enum logic [2:0] {
		S_IDLE, S_READ, S_EXEC, S_BCHK, S_BREAD, S_BMOVE, S_OUT
	} state_t;
	state_t state_q;
	logic boosted_q;

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign out_boosted = boosted_q;

	always_comb begin
		case (state_q)
			S_IDLE: op = !in_valid ? mlfq_pkg::OP_NONE :
				in_mode ? mlfq_pkg::OP_TICK_FIND : mlfq_pkg::OP_ADMIT;
			S_READ: op = mlfq_pkg::OP_TICK_READ;
			S_EXEC: op = mlfq_pkg::OP_TICK_EXEC;
			S_BCHK: op = (st.found && st.boundary && st.any_queued) ?
				mlfq_pkg::OP_BOOST_START : mlfq_pkg::OP_NONE;
			S_BREAD: op = mlfq_pkg::OP_BOOST_READ;
			S_BMOVE: op = mlfq_pkg::OP_BOOST_MOVE;
			default: op = mlfq_pkg::OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			boosted_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: if (in_valid) begin
					boosted_q <= 1'b0;
					state_q <= in_mode ? S_READ : S_OUT;
				end
				S_READ: state_q <= S_EXEC;
				S_EXEC: state_q <= S_BCHK;
				S_BCHK: if (st.found && st.boundary && st.any_queued) begin
					boosted_q <= 1'b1;
					state_q <= S_BREAD;
				end else
					state_q <= S_OUT;
				// read stage steps level when count is exhausted
				S_BREAD: begin
					if (st.boost_more)
						state_q <= S_BMOVE;
					else if (st.boost_last)
						state_q <= S_OUT;
				end
				S_BMOVE: state_q <= S_BREAD;
				S_OUT: if (out_ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

@@ src/mlfq_checker.sv @@
// Port-level checks for the scheduler, bound to the top level.
`timescale 1ns / 1ps
module mlfq_checker (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	input logic s_axis_tready,
	input logic s_axis_tuser,
	input logic m_axis_tvalid,
	input logic m_axis_tready,
	input logic [79:0] m_axis_tdata
);
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !s_axis_tready) else $error("input taken with result pending");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result dropped");
	a_admit_code: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && !s_axis_tuser |=> m_axis_tvalid &&
		(m_axis_tdata[2:0] == mlfq_pkg::ST_ADMIT || m_axis_tdata[2:0] == mlfq_pkg::ST_REJECT))
		else $error("bad admit status");
	a_admit_noboost: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tdata[2:0] == mlfq_pkg::ST_ADMIT ||
		m_axis_tdata[2:0] == mlfq_pkg::ST_REJECT) |-> !m_axis_tdata[44])
		else $error("boost on admit");
endmodule

bind multilevel_feedback_queue_scheduler mlfq_checker u_chk (
	.clk(clk), .arst_n(arst_n), .s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready), .s_axis_tuser(s_axis_tuser),
	.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
	.m_axis_tdata(m_axis_tdata)
);

@@ tb/testbench.sv @@
// Self-checking testbench for the multilevel feedback queue scheduler.
`timescale 1ns / 1ps
module testbench;
	typedef struct packed {
		logic mode;
		logic [5:0] id;
		logic [15:0] len;
	} job_req_t;

	typedef struct packed {
		logic [2:0] status;
		logic [5:0] ran_id;
		logic [2:0] ran_level;
		logic [31:0] turnaround;
		logic boosted;
		logic [31:0] now;
	} sched_res_t;

	logic clk = 0;
	logic arst_n = 0;
	logic s_axis_tvalid = 0;
	logic s_axis_tready;
	logic [23:0] s_axis_tdata = '0;
	logic s_axis_tuser = 0;
	logic m_axis_tvalid;
	logic m_axis_tready = 0;
	logic [79:0] m_axis_tdata;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [4:0] paddr = '0;
	logic [63:0] pwdata = '0;
	logic [63:0] prdata;
	logic pready;

	multilevel_feedback_queue_scheduler u_dut (.*);

	always #5 clk = ~clk;

	// scheduler shadow state
	mlfq_pkg::job_t sh_store [mlfq_pkg::LEVELS][mlfq_pkg::LEVEL_DEPTH];
	int sh_head [mlfq_pkg::LEVELS], sh_tail [mlfq_pkg::LEVELS], sh_fill [mlfq_pkg::LEVELS];
	logic [31:0] sh_time;
	logic [15:0] sh_countdown;
	bit sh_started;
	logic [3:0] cfg_levels;
	logic [63:0] cfg_slices;
	logic [15:0] cfg_boost;

	job_req_t pending_jobs [$];
	sched_res_t expected_res [$];
	int in_idle_pct = 0, out_stall_pct = 0;
	int errors = 0;

	function automatic void sh_push(int lv, mlfq_pkg::job_t e);
		sh_store[lv][sh_tail[lv]] = e;
		sh_tail[lv] = (sh_tail[lv] + 1) % mlfq_pkg::LEVEL_DEPTH;
		sh_fill[lv]++;
	endfunction

	function automatic mlfq_pkg::job_t sh_pop(int lv);
		mlfq_pkg::job_t e;
		e = sh_store[lv][sh_head[lv]];
		sh_head[lv] = (sh_head[lv] + 1) % mlfq_pkg::LEVEL_DEPTH;
		sh_fill[lv]--;
		return e;
	endfunction

	function automatic sched_res_t schedule_step(job_req_t r);
		sched_res_t o;
		mlfq_pkg::job_t e;
		int nlv, lv, n, tgt, total, slice;
		bit found, boundary;
		o = '0;
		found = 0;
		boundary = 0;
		if (r.mode == 1'b0) begin
			o.ran_id = r.id;
			if (sh_fill[0] >= mlfq_pkg::LEVEL_DEPTH) begin
				o.status = mlfq_pkg::ST_REJECT;
			end else begin
				e.id = r.id;
				e.remaining = r.len;
				e.used = 0;
				e.arrival = sh_time;
				sh_push(0, e);
				if (!sh_started) begin
					sh_started = 1;
					sh_countdown = cfg_boost;
				end
				o.status = mlfq_pkg::ST_ADMIT;
			end
		end else begin
			nlv = (cfg_levels == 0) ? 1 :
				(cfg_levels > mlfq_pkg::LEVELS) ? mlfq_pkg::LEVELS : int'(cfg_levels);
			for (lv = 0; lv < nlv; lv++) begin
				if (sh_fill[lv] > 0) begin
					found = 1;
					break;
				end
			end
			sh_time++;
			if (sh_started && cfg_boost != 0) begin
				if (sh_countdown <= 1) begin
					boundary = 1;
					sh_countdown = cfg_boost;
				end else begin
					sh_countdown--;
				end
			end
			if (found) begin
				e = sh_store[lv][sh_head[lv]];
				slice = int'(cfg_slices[8*lv +: 8]);
				o.ran_id = e.id;
				o.ran_level = 3'(lv);
				if (e.remaining <= 1) begin
					o.turnaround = sh_time - e.arrival;
					o.status = mlfq_pkg::ST_DONE;
					void'(sh_pop(lv));
				end else begin
					e.remaining--;
					if (e.used < 255) e.used++;
					sh_store[lv][sh_head[lv]] = e;
					o.status = mlfq_pkg::ST_RAN;
					if (e.used >= slice) begin
						e = sh_pop(lv);
						e.used = 0;
						tgt = lv;
						if (lv + 1 < nlv && sh_fill[lv+1] < mlfq_pkg::LEVEL_DEPTH) tgt = lv + 1;
						sh_push(tgt, e);
					end
				end
				if (boundary) begin
					total = 0;
					for (int k = 0; k < mlfq_pkg::LEVELS; k++) total += sh_fill[k];
					if (total > 0) begin
						for (int l = 1; l < mlfq_pkg::LEVELS; l++) begin
							n = sh_fill[l];
							for (int k = 0; k < n; k++) begin
								e = sh_pop(l);
								if (sh_fill[0] < mlfq_pkg::LEVEL_DEPTH) begin
									e.used = 0;
									sh_push(0, e);
								end else begin
									sh_push(l, e);
								end
							end
						end
						o.boosted = 1;
					end
				end
			end
		end
		o.now = sh_time;
		return o;
	endfunction

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (!s_axis_tvalid || s_axis_tready) begin
				if (pending_jobs.size() > 0 && $urandom_range(99) >= in_idle_pct) begin
					job_req_t r;
					r = pending_jobs.pop_front();
					expected_res.push_back(schedule_step(r));
					s_axis_tvalid <= 1;
					s_axis_tuser <= r.mode;
					s_axis_tdata <= {2'b0, r.len, r.id};
				end else begin
					s_axis_tvalid <= 0;
				end
			end
			m_axis_tready <= ($urandom_range(99) >= out_stall_pct);
		end
	end

	// monitor
	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready) begin
			sched_res_t got, want;
			got.status = m_axis_tdata[2:0];
			got.ran_id = m_axis_tdata[8:3];
			got.ran_level = m_axis_tdata[11:9];
			got.turnaround = m_axis_tdata[43:12];
			got.boosted = m_axis_tdata[44];
			got.now = m_axis_tdata[76:45];
			if (expected_res.size() == 0) begin
				$display("%0t: unexpected beat %h", $time, m_axis_tdata);
				errors++;
			end else begin
				want = expected_res.pop_front();
				if (got.status !== want.status)
					$display("%0t: status exp %0d got %0d", $time, want.status, got.status);
				if (got.ran_id !== want.ran_id)
					$display("%0t: ran_id exp %0d got %0d", $time, want.ran_id, got.ran_id);
				if (got.ran_level !== want.ran_level)
					$display("%0t: ran_level exp %0d got %0d", $time, want.ran_level,
						got.ran_level);
				if (got.turnaround !== want.turnaround)
					$display("%0t: turnaround exp %0d got %0d", $time, want.turnaround,
						got.turnaround);
				if (got.boosted !== want.boosted)
					$display("%0t: boosted exp %0d got %0d", $time, want.boosted, got.boosted);
				if (got.now !== want.now)
					$display("%0t: now exp %0d got %0d", $time, want.now, got.now);
				if (got !== want) errors++;
			end
		end
	end

	task automatic reg_write(logic [1:0] idx, logic [63:0] val);
		@(posedge clk);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= {idx, 3'b000};
		pwdata <= val;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		case (idx)
			mlfq_pkg::REG_LEVEL_COUNT: cfg_levels = val[3:0];
			mlfq_pkg::REG_SLICE: cfg_slices = val;
			default: cfg_boost = val[15:0];
		endcase
	endtask

	task automatic drain();
		while (pending_jobs.size() > 0 || expected_res.size() > 0 || s_axis_tvalid)
			@(posedge clk);
		repeat (4000) @(posedge clk);
	endtask

	function automatic void add(bit m, logic [5:0] id, logic [15:0] len);
		job_req_t r;
		r.mode = m;
		r.id = id;
		r.len = len;
		pending_jobs.push_back(r);
	endfunction

	// mostly short jobs; some long ones and zero length
	function automatic void add_random(int n);
		logic [15:0] len;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(99) < 40) begin
				case ($urandom_range(9))
					0: len = 16'($urandom);
					1: len = '0;
					2: len = 16'hffff;
					default: len = 16'($urandom_range(1, 12));
				endcase
				add(0, 6'($urandom), len);
			end else begin
				add(1, 6'($urandom), 16'($urandom));
			end
		end
	endfunction

	initial begin
		for (int l = 0; l < mlfq_pkg::LEVELS; l++) begin
			sh_head[l] = 0;
			sh_tail[l] = 0;
			sh_fill[l] = 0;
		end
		sh_time = 0;
		sh_countdown = 0;
		sh_started = 0;
		cfg_levels = 3;
		cfg_slices = 64'd578437695752307201;
		cfg_boost = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1;
		repeat (2) @(posedge clk);

		// directed: idle tick, extremes, zero length, demotion
		add(1, 6'h3f, 16'hffff);
		add(0, 6'h00, 16'h0000);
		add(0, 6'h3f, 16'hffff);
		add(0, 6'h15, 16'd3);
		add(0, 6'h2a, 16'h5555);
		for (int i = 0; i < 10; i++) add(1, 6'h00, 16'h0000);
		drain();

		// fill level 0 to overflow, zero slices, zero level count
		reg_write(mlfq_pkg::REG_LEVEL_COUNT, 64'd0);
		reg_write(mlfq_pkg::REG_SLICE, 64'h0);
		reg_write(mlfq_pkg::REG_BOOST, 64'd1);
		for (int i = 0; i < 66; i++) add(0, 6'(i), 16'($urandom_range(1, 4)));
		for (int i = 0; i < 8; i++) add(1, 6'h00, 16'h0000);
		drain();

		reg_write(mlfq_pkg::REG_LEVEL_COUNT, 64'hf);
		reg_write(mlfq_pkg::REG_SLICE, 64'h0403020101010101);
		reg_write(mlfq_pkg::REG_BOOST, 64'd5);
		in_idle_pct = 0;
		out_stall_pct = 0;
		add_random(200);
		drain();

		reg_write(mlfq_pkg::REG_LEVEL_COUNT, 64'd2);
		reg_write(mlfq_pkg::REG_SLICE, 64'hffffffffffffffff);
		reg_write(mlfq_pkg::REG_BOOST, 64'hffff);
		in_idle_pct = 80;
		add_random(200);
		drain();

		reg_write(mlfq_pkg::REG_LEVEL_COUNT, 64'd8);
		reg_write(mlfq_pkg::REG_SLICE, {$urandom, $urandom} & 64'h0707070707070707);
		reg_write(mlfq_pkg::REG_BOOST, 64'd3);
		in_idle_pct = 0;
		out_stall_pct = 80;
		add_random(200);
		drain();

		reg_write(mlfq_pkg::REG_LEVEL_COUNT, 64'd5);
		reg_write(mlfq_pkg::REG_BOOST, 64'd0);
		in_idle_pct = 11;
		out_stall_pct = 11;
		add_random(200);
		drain();

		if (errors == 0 && expected_res.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin
		#50ms;
		$display("status: fail");
		$finish;
	end
endmodule
